// ===== rtl/nfba_pkg.sv =====
// Package with shared types and constants for the next-fit bitmap allocator.
`timescale 1ns / 1ps
package nfba_pkg;

  localparam int MAP_BYTES = 512;
  localparam int ADDR_W    = $clog2(MAP_BYTES);
  localparam int CFG_W     = 10;
  localparam int UNIT_W    = 13;
  localparam int IDX_W     = 12;
  localparam int CNT_W     = 13;

  localparam logic       OP_ALLOC = 1'b0;
  localparam logic       OP_FREE  = 1'b1;
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOSPC  = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  typedef struct packed {
    logic             op;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] start_index;
  } nfba_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] run_start;
  } nfba_out_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_EV, S_MOD_RD, S_MOD_WR, S_DONE
  } nfba_state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic dispatch;
    logic scan_rd;
    logic scan_ev;
    logic mod_rd;
    logic mod_wr;
  } nfba_cmd_t;

  typedef struct packed {
    logic is_free;
    logic free_bad;
    logic count_zero;
    logic scan_hit;
    logic scan_fail;
    logic mod_last;
    logic clr_last;
  } nfba_stat_t;

endpackage

// ===== rtl/nfba_ctrl.sv =====
// Controller state machine sequencing clear, scan and bitmap update.
`timescale 1ns / 1ps
module nfba_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  nfba_pkg::nfba_stat_t stat,
  output nfba_pkg::nfba_cmd_t  cmd,
  output logic               busy,
  output logic               done
);
  import nfba_pkg::*;

  nfba_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:    if (stat.clr_last) state_next = S_IDLE;
      S_IDLE:     if (start) state_next = S_DISPATCH;
      S_DISPATCH: begin
        if (stat.is_free) begin
          state_next = (stat.free_bad || stat.count_zero) ? S_DONE : S_MOD_RD;
        end else begin
          state_next = stat.count_zero ? S_DONE : S_SCAN_RD;
        end
      end
      S_SCAN_RD:  state_next = S_SCAN_EV;
      S_SCAN_EV: begin
        if (stat.scan_hit) state_next = S_MOD_RD;
        else if (stat.scan_fail) state_next = S_DONE;
        else state_next = S_SCAN_RD;
      end
      S_MOD_RD:   state_next = S_MOD_WR;
      S_MOD_WR:   state_next = stat.mod_last ? S_DONE : S_MOD_RD;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd          = '0;
    busy         = 1'b1;
    done         = 1'b0;
    case (state)
      S_CLEAR:    cmd.clear = 1'b1;
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_DISPATCH: cmd.dispatch = 1'b1;
      S_SCAN_RD:  cmd.scan_rd = 1'b1;
      S_SCAN_EV:  cmd.scan_ev = 1'b1;
      S_MOD_RD:   cmd.mod_rd = 1'b1;
      S_MOD_WR:   cmd.mod_wr = 1'b1;
      S_DONE:     done = 1'b1;
      default:    busy = 1'b1;
    endcase
  end

endmodule

// ===== rtl/nfba_datapath.sv =====
// Datapath with the bitmap memory, cursor, scan logic and result registers.
`timescale 1ns / 1ps
module nfba_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  nfba_pkg::nfba_cmd_t         cmd,
  input  nfba_pkg::nfba_in_t          item,
  input  logic                        cfg_we,
  input  logic [nfba_pkg::CFG_W-1:0]  cfg_wdata,
  output nfba_pkg::nfba_stat_t        stat,
  output nfba_pkg::nfba_out_t         result
);
  import nfba_pkg::*;

  logic [7:0]        mem [MAP_BYTES];
  logic [7:0]        rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              wr_en;

  logic [CFG_W-1:0]  cfg_bytes;
  logic [ADDR_W-1:0] clr_addr;
  logic              op;
  logic [CNT_W-1:0]  count;
  logic              free_bad;
  logic [IDX_W-1:0]  cursor;
  logic [IDX_W-1:0]  pos;
  logic [ADDR_W-1:0] start_byte;
  logic [ADDR_W-1:0] byte_at;
  logic              first_byte;
  logic [CNT_W-1:0]  found;
  logic [IDX_W-1:0]  lo;
  logic [UNIT_W-1:0] hi;
  logic [ADDR_W-1:0] mod_byte;
  logic [1:0]        res_status;
  logic [IDX_W-1:0]  res_run;

  logic [CFG_W-1:0]  m;
  logic [UNIT_W-1:0] units;
  logic [IDX_W-1:0]  pos_w;
  logic [UNIT_W:0]   free_end;
  logic [UNIT_W-1:0] hi_m1;
  logic [ADDR_W-1:0] last_byte;
  logic [7:0]        mask;

  logic [CNT_W-1:0]  f;
  logic              hit;
  logic [3:0]        end_bit;
  logic [2:0]        bit0;
  logic [UNIT_W-1:0] end_unit;
  logic [UNIT_W-1:0] lo_hit;
  logic [CFG_W-1:0]  next_byte;
  logic [ADDR_W-1:0] nb;
  logic              wrap;
  logic              fail;

  always_comb begin
    if (cfg_bytes == '0) m = CFG_W'(1);
    else if (cfg_bytes > CFG_W'(MAP_BYTES)) m = CFG_W'(MAP_BYTES);
    else m = cfg_bytes;
  end

  assign units     = {m, 3'b000};
  assign pos_w     = ({1'b0, cursor} >= units) ? '0 : cursor;
  assign free_end  = {2'b00, item.start_index} + {1'b0, item.count};
  assign hi_m1     = hi - UNIT_W'(1);
  assign last_byte = hi_m1[IDX_W-1:3];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mask[i] = ({1'b0, mod_byte, 3'(i)} >= {1'b0, lo}) && ({1'b0, mod_byte, 3'(i)} < hi);
    end
  end

  always_comb begin
    f       = found;
    hit     = 1'b0;
    end_bit = '0;
    bit0    = first_byte ? pos[2:0] : 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (!hit && (3'(i) >= bit0)) begin
        if (rd_data[i]) f = '0;
        else f = f + CNT_W'(1);
        if (f == count) begin
          hit     = 1'b1;
          end_bit = 4'(i + 1);
        end
      end
    end
  end

  assign end_unit  = {1'b0, byte_at, 3'b000} + UNIT_W'(end_bit);
  assign lo_hit    = end_unit - count;
  assign next_byte = {1'b0, byte_at} + CFG_W'(1);
  assign wrap      = next_byte >= m;
  assign nb        = wrap ? '0 : next_byte[ADDR_W-1:0];
  assign fail      = nb == start_byte;

  assign rd_addr = cmd.scan_rd ? byte_at : mod_byte;
  assign wr_en   = cmd.clear || cmd.mod_wr;
  assign wr_addr = cmd.clear ? clr_addr : mod_byte;
  assign wr_data = cmd.clear ? 8'h00 : (op == OP_ALLOC) ? (rd_data | mask) : (rd_data & ~mask);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.scan_rd || cmd.mod_rd) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_bytes <= CFG_W'(MAP_BYTES);
      clr_addr  <= '0;
      cursor    <= '0;
    end else begin
      if (cfg_we) cfg_bytes <= cfg_wdata;
      if (cmd.clear) clr_addr <= clr_addr + ADDR_W'(1);
      if (cmd.dispatch && op == OP_ALLOC && count == '0) cursor <= pos;
      if (cmd.scan_ev) begin
        if (hit) cursor <= (end_unit >= units) ? '0 : end_unit[IDX_W-1:0];
        else if (fail) cursor <= pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op         <= item.op;
      count      <= item.count;
      free_bad   <= free_end > {1'b0, units};
      pos        <= pos_w;
      start_byte <= pos_w[IDX_W-1:3];
      byte_at    <= pos_w[IDX_W-1:3];
      first_byte <= 1'b1;
      found      <= '0;
      lo         <= item.start_index;
      hi         <= free_end[UNIT_W-1:0];
    end
    if (cmd.dispatch) begin
      mod_byte   <= lo[IDX_W-1:3];
      res_run    <= (op == OP_ALLOC && count == '0) ? pos : '0;
      res_status <= (op == OP_FREE && free_bad) ? ST_RANGE : ST_OK;
    end
    if (cmd.scan_ev) begin
      if (hit) begin
        lo       <= lo_hit[IDX_W-1:0];
        hi       <= end_unit;
        mod_byte <= lo_hit[IDX_W-1:3];
        res_run  <= lo_hit[IDX_W-1:0];
      end else begin
        byte_at    <= nb;
        first_byte <= 1'b0;
        found      <= wrap ? '0 : f;
        if (fail) res_status <= ST_NOSPC;
      end
    end
    if (cmd.mod_wr) begin
      mod_byte <= mod_byte + ADDR_W'(1);
    end
  end

  always_comb begin
    stat.is_free    = op == OP_FREE;
    stat.free_bad   = free_bad;
    stat.count_zero = count == '0;
    stat.scan_hit   = hit;
    stat.scan_fail  = fail;
    stat.mod_last   = mod_byte == last_byte;
    stat.clr_last   = clr_addr == ADDR_W'(MAP_BYTES - 1);
  end

  assign result.status    = res_status;
  assign result.run_start = res_run;

endmodule

// ===== rtl/next_fit_bitmap_allocator.sv =====
// Top level of the next-fit bitmap allocator.
//
//   Channel  Signals                      Transfer when
//   item     start, busy, item            start high and busy low
//   result   done, result                 done high, one cycle, never held
//   config   cfg_we, cfg_wdata            cfg_we high
//
// After reset the bitmap's 512 bytes are cleared one byte a cycle with busy high.
// An allocate reads and evaluates each scanned byte, then reads and writes each marked byte.
// A free reads and writes each touched byte; range errors go straight to done.
// Results cannot be stalled.
`timescale 1ns / 1ps
module next_fit_bitmap_allocator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  nfba_pkg::nfba_in_t         item,
  output logic                       done,
  output nfba_pkg::nfba_out_t        result,
  input  logic                       cfg_we,
  input  logic [nfba_pkg::CFG_W-1:0] cfg_wdata
);
  import nfba_pkg::*;

  nfba_cmd_t  cmd;
  nfba_stat_t stat;

  nfba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  nfba_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .result    (result)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after transfer");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result while idle");

  a_run_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ST_OK |-> result.run_start == '0)
    else $error("run start set on failed item");

endmodule
